// File: rtl/core/v22_pkg.sv
// Shared stage codes, timing constants and types for the V.22bis symbol generator.
`default_nettype none
package v22_pkg;

    localparam int unsigned STAGE_W = 3;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned SHIFT_W = 23;
    localparam int unsigned RUN_W   = 7;

    localparam logic [STAGE_W-1:0] ST_DATA      = 3'd0;
    localparam logic [STAGE_W-1:0] ST_SILENCE   = 3'd1;
    localparam logic [STAGE_W-1:0] ST_U11       = 3'd2;
    localparam logic [STAGE_W-1:0] ST_U0011     = 3'd3;
    localparam logic [STAGE_W-1:0] ST_TIMED_S11 = 3'd4;
    localparam logic [STAGE_W-1:0] ST_S11       = 3'd5;
    localparam logic [STAGE_W-1:0] ST_S1111     = 3'd6;
    localparam logic [STAGE_W-1:0] ST_PARKED    = 3'd7;

    localparam logic [COUNT_W-1:0] SYMS_SILENCE     = 9'd45;
    localparam logic [COUNT_W-1:0] SYMS_U0011       = 9'd60;
    localparam logic [COUNT_W-1:0] SYMS_TIMED_START = 9'd153;
    localparam logic [COUNT_W-1:0] SYMS_TIMED_END   = 9'd453;
    localparam logic [COUNT_W-1:0] SYMS_S1111       = 9'd120;

    localparam logic [RUN_W-1:0] ONES_LIMIT = 7'd64;

    // Calling-side taps 14/17, answering-side taps 18/23 (one-based stage numbers)
    localparam int unsigned TAP_A_CALL = 13;
    localparam int unsigned TAP_B_CALL = 16;
    localparam int unsigned TAP_A_ANS  = 17;
    localparam int unsigned TAP_B_ANS  = 22;

    localparam logic CFG_CALLING = 1'b0;
    localparam logic CFG_POLY    = 1'b1;

    // Quadrant increment per dibit
    localparam logic [1:0] QUAD_STEP [4] = '{2'd1, 2'd0, 2'd2, 2'd3};

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [RUN_W-1:0]   run;
    } t_scr_state;

endpackage
`default_nettype wire

// File: rtl/core/v22_scr.sv
// Self-synchronising scrambler with ones-run breaker, two or four bits per symbol.
`default_nettype none
module v22_scr
    import v22_pkg::*;
(
    input  var t_scr_state i_state,
    input  wire [3:0]      i_bits,   // bit 3 enters first
    input  wire            i_four,
    input  wire            i_poly,
    output t_scr_state     o_state,
    output logic [3:0]     o_bits    // bit 3 leaves first
);

    t_scr_state step_state [5];

    always_comb begin
        logic b;
        logic o;
        step_state[0] = i_state;
        o_bits = '0;
        for (int k = 0; k < 4; k++) begin
            b = i_bits[3-k];
            step_state[k+1].run = step_state[k].run;
            if (step_state[k].run >= ONES_LIMIT) begin
                b = ~b;
                step_state[k+1].run = '0;
            end
            if (i_poly) begin
                o = b ^ step_state[k].shift[TAP_A_ANS] ^ step_state[k].shift[TAP_B_ANS];
            end else begin
                o = b ^ step_state[k].shift[TAP_A_CALL] ^ step_state[k].shift[TAP_B_CALL];
            end
            step_state[k+1].shift = {step_state[k].shift[SHIFT_W-2:0], o};
            step_state[k+1].run   = o ? step_state[k+1].run + 7'd1 : '0;
            o_bits[3-k] = o;
        end
        o_state = i_four ? step_state[4] : step_state[2];
    end

endmodule
`default_nettype wire

// File: rtl/core/v22bis_symbol_generator.sv
// V.22bis transmit symbol generator: scrambler, differential quadrant coder, training sequencer.
// Each result is registered in the output register when its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the scrambler (up to four
// chained steps) and the stage sequencer update their state in the same cycle the item is taken.
// Reset (synchronous, active low): scrambler and ones-run cleared, quadrant 0, stage
// initial silence, counter 0, configuration registers 0, output register empty.
`default_nettype none
module v22bis_symbol_generator
    import v22_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire        i_cfg_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // data_bits[3:0], rate_2400[4], new_stage[7:5]
    input  wire        s_axis_tuser,   // action
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // point_index[3:0], bits_used[6:4], stage_now[9:7], zeros
    output logic       m_axis_tuser    // silent
);

    logic r_calling, r_poly;
    t_scr_state r_scr, scr_next;
    logic [1:0] r_quad, n_quad;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [COUNT_W-1:0] r_count, n_count, count_inc;

    logic r_m_valid;
    logic [3:0] r_point;
    logic [2:0] r_used;
    logic [STAGE_W-1:0] r_stage_out;
    logic r_silent;

    logic accept;
    logic [3:0] data_bits;
    logic rate_2400;
    logic [STAGE_W-1:0] new_stage;

    logic [3:0] scr_in, scr_out;
    logic scr_four, scr_en;
    logic [1:0] inner;
    logic silent;
    logic [2:0] used;

    assign data_bits = s_axis_tdata[3:0];
    assign rate_2400 = s_axis_tdata[4];
    assign new_stage = s_axis_tdata[7:5];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign count_inc = r_count + 9'd1;

    v22_scr u_scr (
        .i_state (r_scr),
        .i_bits  (scr_in),
        .i_four  (scr_four),
        .i_poly  (r_poly),
        .o_state (scr_next),
        .o_bits  (scr_out)
    );

    always_comb begin
        n_quad   = r_quad;
        n_stage  = r_stage;
        n_count  = r_count;
        scr_in   = 4'b1111;
        scr_four = 1'b0;
        scr_en   = 1'b0;
        inner    = 2'd1;
        silent   = 1'b0;
        used     = 3'd0;
        if (s_axis_tuser) begin
            n_stage = new_stage;
            n_count = '0;
            silent  = 1'b1;
        end else begin
            unique case (r_stage)
                ST_DATA: begin
                    scr_in   = data_bits;
                    scr_four = rate_2400;
                    scr_en   = 1'b1;
                    n_quad   = r_quad + QUAD_STEP[scr_out[3:2]];
                    if (rate_2400) begin
                        inner = scr_out[1:0];
                        used  = 3'd4;
                    end else begin
                        used  = 3'd2;
                    end
                end
                ST_SILENCE: begin
                    n_quad = '0;
                    silent = 1'b1;
                    if (!r_calling) begin
                        n_count = count_inc;
                        if (count_inc >= SYMS_SILENCE) begin
                            n_count = '0;
                            n_stage = ST_U11;
                        end
                    end
                end
                ST_U11: begin
                    n_quad = r_quad + QUAD_STEP[2'd3];
                end
                ST_U0011: begin
                    n_quad  = r_quad + (r_count[0] ? QUAD_STEP[2'd3] : QUAD_STEP[2'd0]);
                    n_count = count_inc;
                    if (count_inc >= SYMS_U0011) begin
                        if (r_calling) begin
                            n_count = '0;
                            n_stage = ST_S11;
                        end else begin
                            n_count = SYMS_TIMED_START;
                            n_stage = ST_TIMED_S11;
                        end
                    end
                end
                ST_TIMED_S11, ST_S11: begin
                    scr_en = 1'b1;
                    n_quad = r_quad + QUAD_STEP[scr_out[3:2]];
                    if (r_stage == ST_TIMED_S11) begin
                        n_count = count_inc;
                        if (count_inc >= SYMS_TIMED_END) begin
                            n_count = '0;
                            n_stage = rate_2400 ? ST_S1111 : ST_DATA;
                        end
                    end
                end
                ST_S1111: begin
                    scr_four = 1'b1;
                    scr_en   = 1'b1;
                    n_quad   = r_quad + QUAD_STEP[scr_out[3:2]];
                    inner    = scr_out[1:0];
                    n_count  = count_inc;
                    if (count_inc >= SYMS_S1111) begin
                        n_count = '0;
                        n_stage = ST_DATA;
                    end
                end
                ST_PARKED: begin
                    silent = 1'b1;
                end
                default: begin
                    silent = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calling <= 1'b0;
            r_poly    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CALLING: r_calling <= i_cfg_data;
                CFG_POLY:    r_poly    <= i_cfg_data;
                default:     r_poly    <= r_poly;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr     <= '0;
            r_quad    <= '0;
            r_stage   <= ST_SILENCE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (scr_en) begin
                    r_scr <= scr_next;
                end
                r_quad    <= n_quad;
                r_stage   <= n_stage;
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload of the result register: no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_point     <= silent ? 4'd0 : {n_quad, inner};
            r_silent    <= silent;
            r_used      <= used;
            r_stage_out <= n_stage;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_silent;
    assign m_axis_tdata  = {6'd0, r_stage_out, r_used, r_point};

endmodule
`default_nettype wire

// File: verif/v22bis_symbol_generator_tb.sv
// Self-checking testbench for the V.22bis symbol generator: training stages, scrambler and mapper.
module v22bis_symbol_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import v22_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam logic [1:0]  QUAD_TURN [4] = '{2'd1, 2'd0, 2'd2, 2'd3};

    typedef struct packed {
        logic [3:0]         point;
        logic               silent;
        logic [2:0]         used;
        logic [STAGE_W-1:0] stage;
    } t_symbol;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic        i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_bits[3:0], rate_2400[4], new_stage[7:5]
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // point_index[3:0], bits_used[6:4], stage_now[9:7], zeros
    logic        m_axis_tuser;   // silent

    // Predicted block state
    logic               cfg_calling = 1'b0;
    logic               cfg_poly    = 1'b0;
    t_scr_state         scr         = '0;
    logic [1:0]         quad        = '0;
    logic [STAGE_W-1:0] stg         = ST_SILENCE;
    logic [COUNT_W-1:0] cnt         = '0;

    t_symbol     expected_symbols[$];
    t_symbol     want_sym;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    logic        tx_idle      = 1'b1;
    logic        rx_idle      = 1'b1;
    int unsigned rx_hold_req  = 0;
    int unsigned rx_stall     = 0;

    v22bis_symbol_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_symbols.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic coin();
        return $urandom_range(0, 1);
    endfunction

    function automatic logic [3:0] any_nibble();
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [2:0] any_stage();
        return $urandom_range(0, 7);
    endfunction

    function automatic logic tap_xor();
        if (cfg_poly)
            return scr.shift[TAP_A_ANS] ^ scr.shift[TAP_B_ANS];
        return scr.shift[TAP_A_CALL] ^ scr.shift[TAP_B_CALL];
    endfunction

    function automatic logic scramble_bit(input logic b);
        logic fb;
        logic o;
        fb = b;
        // break a long run of scrambled ones by inverting the next input bit
        if (scr.run >= ONES_LIMIT) begin
            fb = ~fb;
            scr.run = '0;
        end
        o = fb ^ tap_xor();
        scr.shift = {scr.shift[SHIFT_W-2:0], o};
        scr.run = o ? scr.run + 1'b1 : '0;
        return o;
    endfunction

    function automatic logic [1:0] scramble_pair(input logic hi, input logic lo);
        logic a;
        a = scramble_bit(hi);
        return {a, scramble_bit(lo)};
    endfunction

    function automatic void turn_quadrant(input logic [1:0] dibit);
        quad = quad + QUAD_TURN[dibit];
    endfunction

    function automatic t_symbol predict_symbol(input logic act, input logic [3:0] d,
                                               input logic r, input logic [2:0] ns);
        t_symbol    s;
        logic [1:0] inner;
        s = '0;
        if (act) begin
            stg = ns;
            cnt = '0;
            s.silent = 1'b1;
        end else begin
            case (stg)
                ST_DATA: begin
                    turn_quadrant(scramble_pair(d[3], d[2]));
                    if (r) begin
                        inner = scramble_pair(d[1], d[0]);
                        s.used = 3'd4;
                    end else begin
                        inner = 2'b01;
                        s.used = 3'd2;
                    end
                    s.point = {quad, inner};
                end
                ST_SILENCE: begin
                    quad = '0;
                    s.silent = 1'b1;
                    // only the answering side leaves initial silence by itself
                    if (!cfg_calling) begin
                        cnt = cnt + 1'b1;
                        if (cnt >= SYMS_SILENCE) begin
                            cnt = '0;
                            stg = ST_U11;
                        end
                    end
                end
                ST_U11: begin
                    turn_quadrant(2'b11);
                    s.point = {quad, 2'b01};
                end
                ST_U0011: begin
                    turn_quadrant(cnt[0] ? 2'b11 : 2'b00);
                    cnt = cnt + 1'b1;
                    if (cnt >= SYMS_U0011) begin
                        if (cfg_calling) begin
                            cnt = '0;
                            stg = ST_S11;
                        end else begin
                            cnt = SYMS_TIMED_START;
                            stg = ST_TIMED_S11;
                        end
                    end
                    s.point = {quad, 2'b01};
                end
                ST_TIMED_S11, ST_S11: begin
                    if (stg == ST_TIMED_S11) begin
                        cnt = cnt + 1'b1;
                        if (cnt >= SYMS_TIMED_END) begin
                            cnt = '0;
                            stg = r ? ST_S1111 : ST_DATA;
                        end
                    end
                    turn_quadrant(scramble_pair(1'b1, 1'b1));
                    s.point = {quad, 2'b01};
                end
                ST_S1111: begin
                    turn_quadrant(scramble_pair(1'b1, 1'b1));
                    inner = scramble_pair(1'b1, 1'b1);
                    cnt = cnt + 1'b1;
                    if (cnt >= SYMS_S1111) begin
                        cnt = '0;
                        stg = ST_DATA;
                    end
                    s.point = {quad, inner};
                end
                default: s.silent = 1'b1;
            endcase
        end
        s.stage = stg;
        return s;
    endfunction

    // Pick source bits that scramble to ones, so the run breaker gets exercised
    function automatic logic [3:0] ones_data(input logic r);
        t_scr_state saved;
        logic [3:0] d;
        saved = scr;
        d = any_nibble();
        for (int k = 3; k >= (r ? 0 : 2); k--) begin
            d[k] = ~tap_xor();
            void'(scramble_bit(d[k]));
        end
        scr = saved;
        return d;
    endfunction

    function automatic int unsigned tx_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!tx_idle || roll >= 40)
            return 0;
        if (roll < 5)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_stall = rx_hold_req;
            rx_hold_req = 0;
        end else if (rx_stall == 0 && rx_idle && $urandom_range(0, 99) < 25) begin
            rx_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
        end
        if (rx_stall != 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_symbols.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %h/%b", $time,
                         m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want_sym = expected_symbols.pop_front();
                check_field("point_index", want_sym.point,  m_axis_tdata[3:0]);
                check_field("silent",      want_sym.silent, m_axis_tuser);
                check_field("bits_used",   want_sym.used,   m_axis_tdata[6:4]);
                check_field("stage_now",   want_sym.stage,  m_axis_tdata[9:7]);
            end
        end
    end

    task automatic send_item(input logic act, input logic [3:0] d, input logic r,
                             input logic [2:0] ns);
        int unsigned gap;
        gap = tx_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ns, r, d};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_symbols.push_back(predict_symbol(act, d, r, ns));
    endtask

    task automatic tick(input logic [3:0] d, input logic r);
        send_item(1'b0, d, r, any_stage());
    endtask

    task automatic force_stage(input logic [2:0] ns);
        send_item(1'b1, any_nibble(), coin(), ns);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CALLING)
            cfg_calling = val;
        else
            cfg_poly = val;
    endtask

    task automatic test_stage_forcing();
        write_config(CFG_CALLING, 1'b1);
        write_config(CFG_POLY, 1'b0);
        // calling side sits in initial silence
        tick(any_nibble(), coin());
        tick(any_nibble(), coin());
        force_stage(ST_DATA);
        tick(4'h0, 1'b0);
        tick(4'hF, 1'b1);
        tick(4'hF, 1'b0);
        tick(4'h0, 1'b1);
        force_stage(ST_U11);
        tick(any_nibble(), coin());
        tick(any_nibble(), coin());
        force_stage(ST_U0011);
        repeat (3) tick(any_nibble(), coin());
        force_stage(ST_TIMED_S11);
        tick(any_nibble(), coin());
        force_stage(ST_S11);
        tick(any_nibble(), coin());
        force_stage(ST_S1111);
        tick(any_nibble(), 1'b1);
        force_stage(ST_PARKED);
        tick(any_nibble(), coin());
        force_stage(ST_SILENCE);
        tick(any_nibble(), coin());
    endtask

    task automatic test_silence_timeout();
        write_config(CFG_CALLING, 1'b0);
        force_stage(ST_SILENCE);
        while (stg == ST_SILENCE) tick(any_nibble(), coin());
        repeat (4) tick(any_nibble(), coin());
    endtask

    task automatic test_timed_training(input logic end_rate, input logic poly);
        write_config(CFG_CALLING, 1'b0);
        write_config(CFG_POLY, poly);
        force_stage(ST_U0011);
        // the tick that closes the timed stage chooses what follows
        while (stg == ST_U0011 || stg == ST_TIMED_S11)
            tick(any_nibble(), (stg == ST_TIMED_S11 && cnt == SYMS_TIMED_END - 1'b1)
                               ? end_rate : coin());
        while (stg == ST_S1111) tick(any_nibble(), coin());
        repeat (10) tick(any_nibble(), coin());
    endtask

    task automatic test_calling_training();
        write_config(CFG_CALLING, 1'b1);
        write_config(CFG_POLY, 1'b1);
        force_stage(ST_U0011);
        while (stg == ST_U0011) tick(any_nibble(), coin());
        repeat (8) tick(any_nibble(), coin());
        force_stage(ST_PARKED);
        repeat (3) tick(any_nibble(), coin());
        force_stage(ST_DATA);
        repeat (5) tick(any_nibble(), coin());
    endtask

    task automatic test_ones_breaker();
        logic r;
        write_config(CFG_CALLING, 1'b0);
        for (int p = 0; p < 2; p++) begin
            write_config(CFG_POLY, p[0]);
            force_stage(ST_DATA);
            // mostly four bits a symbol so the run reaches the limit quickly
            repeat (28) begin
                r = ($urandom_range(0, 3) != 0);
                tick(ones_data(r), r);
            end
        end
    endtask

    task automatic test_backpressure();
        force_stage(ST_DATA);
        tx_idle = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        repeat (40) tick(any_nibble(), coin());
        tx_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned len;
        logic        r;
        sent = 0;
        while (sent < 60) begin
            // leave some sequences with no idling at all
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                write_config(CFG_CALLING, coin());
                write_config(CFG_POLY, coin());
            end
            force_stage(coin() ? ST_DATA : any_stage());
            len = $urandom_range(1, 20);
            repeat (len) begin
                case ($urandom_range(0, 19))
                    0: force_stage(any_stage());
                    1, 2, 3: begin
                        r = coin();
                        tick(ones_data(r), r);
                    end
                    default: tick(any_nibble(), coin());
                endcase
            end
            sent += len + 1;
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stage_forcing();
        test_silence_timeout();
        test_timed_training(1'b1, 1'b1);
        test_calling_training();
        test_ones_breaker();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_symbols.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
